>>> design/gcic_pkg.sv
`default_nettype none
package gcic_pkg;

   localparam int COORD_W   = 15;
   localparam int ID_W      = 31;
   localparam int OUT_ID_W  = 32;
   localparam int NDIMS_W   = 3;
   localparam int NFIELD    = 4;
   localparam int MAX_DIMS_DEFAULT = 4;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;
   localparam int FRONT_STAGES = 5;

   localparam logic [1:0] ACT_TO_ID   = 2'd0;
   localparam logic [1:0] ACT_TO_COORD = 2'd1;
   localparam logic [1:0] ACT_NEXT    = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_WRAP  = 2'd2;

   localparam logic [2:0] REG_NUM_DIMS   = 3'd0;
   localparam logic [2:0] REG_SIZE0      = 3'd1;
   localparam logic [2:0] REG_SIZE1      = 3'd2;
   localparam logic [2:0] REG_SIZE2      = 3'd3;
   localparam logic [2:0] REG_SIZE3      = 3'd4;
   localparam logic [2:0] REG_FIRST_CELL = 3'd5;

   typedef logic [NFIELD-1:0][COORD_W-1:0] coord_vec_type;

   // Result fields as they travel down the divider chain.
   typedef struct packed {
      logic [1:0]          act;
      logic [1:0]          status;
      logic [OUT_ID_W-1:0] cell_id;
      coord_vec_type       coord;
   } res_type;

   // Front-end stage contents.
   typedef struct packed {
      logic [1:0]          act;
      logic [ID_W-1:0]     id;
      logic                oor;
      coord_vec_type       coord;
      logic [OUT_ID_W-1:0] acc;
      coord_vec_type       nxt;
      logic                wrap;
   } front_type;

endpackage
`default_nettype wire

>>> design/gcic_div.sv
`default_nettype none
module gcic_div
   import gcic_pkg::*;
#(
   parameter int PAY_W = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic [ID_W-1:0]    in_dividend,
   input  wire logic [COORD_W-1:0] divisor,
   input  wire logic [PAY_W-1:0]   in_payload,
   output logic                    out_valid,
   output logic [ID_W-1:0]         out_quotient,
   output logic [COORD_W-1:0]      out_remainder,
   output logic [PAY_W-1:0]        out_payload
);

   // One quotient bit per stage, most significant first. The dividend bits are
   // replaced by quotient bits as they are produced.
   logic [ID_W-1:0]    vld_ff;
   logic [ID_W-1:0]    word_ff [ID_W];
   logic [COORD_W-1:0] rem_ff  [ID_W];
   logic [PAY_W-1:0]   pay_ff  [ID_W];

   for (genvar i = 0; i < ID_W; i++) begin : g_stage
      logic               vld_prev;
      logic [ID_W-1:0]    word_prev;
      logic [COORD_W-1:0] rem_prev;
      logic [PAY_W-1:0]   pay_prev;
      logic [COORD_W:0]   trial;
      logic               ge;
      logic [ID_W-1:0]    word_in;
      logic [COORD_W-1:0] rem_in;

      if (i == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign word_prev = in_dividend;
         assign rem_prev  = '0;
         assign pay_prev  = in_payload;
      end else begin : g_rest
         assign vld_prev  = vld_ff[i-1];
         assign word_prev = word_ff[i-1];
         assign rem_prev  = rem_ff[i-1];
         assign pay_prev  = pay_ff[i-1];
      end

      always_comb begin
         trial   = {rem_prev, word_prev[ID_W-1-i]};
         ge      = trial >= {1'b0, divisor};
         rem_in  = ge ? COORD_W'(trial - {1'b0, divisor}) : COORD_W'(trial);
         word_in = word_prev;
         word_in[ID_W-1-i] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_prev;
         end
         word_ff[i] <= word_in;
         rem_ff[i]  <= rem_in;
         pay_ff[i]  <= pay_prev;
      end
   end

   assign out_valid     = vld_ff[ID_W-1];
   assign out_quotient  = word_ff[ID_W-1];
   assign out_remainder = rem_ff[ID_W-1];
   assign out_payload   = pay_ff[ID_W-1];

endmodule
`default_nettype wire

>>> design/grid_cell_index_converter_unit.sv
`default_nettype none
// Converts between global cell ids and mixed-radix grid coordinates and steps a
// coordinate set to the next cell. A request is taken in every clock cycle (busy
// never rises) and its result appears on the rsp_ ports, marked by rsp_valid, in
// request order after the front-end stages, the four chained restoring dividers
// of the id-to-coordinates path, one quotient bit per stage, and the output
// register, which every request passes so that results never reorder. The
// receiver cannot stall the block: each result is shown for one cycle only.
// Registers may be written only while no request is in flight.
module grid_cell_index_converter_unit
   import gcic_pkg::*;
#(
   parameter int MAX_DIMS = MAX_DIMS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [1:0]          req_action,
   input  wire logic [ID_W-1:0]     req_in_cell_id,
   input  wire logic [COORD_W-1:0]  req_in_coord0,
   input  wire logic [COORD_W-1:0]  req_in_coord1,
   input  wire logic [COORD_W-1:0]  req_in_coord2,
   input  wire logic [COORD_W-1:0]  req_in_coord3,
   output logic                     rsp_valid,
   output logic [OUT_ID_W-1:0]      rsp_out_cell_id,
   output logic [COORD_W-1:0]       rsp_out_coord0,
   output logic [COORD_W-1:0]       rsp_out_coord1,
   output logic [COORD_W-1:0]       rsp_out_coord2,
   output logic [COORD_W-1:0]       rsp_out_coord3,
   output logic [1:0]               rsp_status,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [ADDR_W-1:0]   paddr,
   input  wire logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]        prdata,
   output logic                     pready
);

   localparam int LIM = (MAX_DIMS < NFIELD) ? MAX_DIMS : NFIELD;
   localparam int LATENCY = FRONT_STAGES + NFIELD * ID_W + 1;
   localparam int PAY_W = $bits(res_type);

   // ---------------- configuration registers ----------------
   logic [NDIMS_W-1:0]  num_dims_ff;
   logic [COORD_W-1:0]  size_ff [NFIELD];
   logic [ID_W-1:0]     first_cell_ff;
   logic                wr_en;
   logic [2:0]          wr_idx;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;
   assign wr_idx = paddr[ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff   <= NDIMS_W'(1);
         first_cell_ff <= '0;
         for (int d = 0; d < NFIELD; d++) begin
            size_ff[d] <= COORD_W'(1);
         end
      end else if (wr_en) begin
         case (wr_idx)
            REG_NUM_DIMS:   num_dims_ff   <= pwdata[NDIMS_W-1:0];
            REG_SIZE0:      size_ff[0]    <= pwdata[COORD_W-1:0];
            REG_SIZE1:      size_ff[1]    <= pwdata[COORD_W-1:0];
            REG_SIZE2:      size_ff[2]    <= pwdata[COORD_W-1:0];
            REG_SIZE3:      size_ff[3]    <= pwdata[COORD_W-1:0];
            REG_FIRST_CELL: first_cell_ff <= pwdata[ID_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (wr_idx)
         REG_NUM_DIMS:   prdata = DATA_W'(num_dims_ff);
         REG_SIZE0:      prdata = DATA_W'(size_ff[0]);
         REG_SIZE1:      prdata = DATA_W'(size_ff[1]);
         REG_SIZE2:      prdata = DATA_W'(size_ff[2]);
         REG_SIZE3:      prdata = DATA_W'(size_ff[3]);
         REG_FIRST_CELL: prdata = DATA_W'(first_cell_ff);
         default:        prdata = '0;
      endcase
   end

   // Effective extents: dimensions not in use and zero sizes count as one.
   logic [NDIMS_W-1:0]  ndims;
   logic [COORD_W-1:0]  ext [NFIELD];
   logic [NFIELD-1:0]   used;

   always_comb begin
      ndims = num_dims_ff;
      if (ndims == '0) begin
         ndims = NDIMS_W'(1);
      end
      if (ndims > NDIMS_W'(LIM)) begin
         ndims = NDIMS_W'(LIM);
      end
      for (int d = 0; d < NFIELD; d++) begin
         used[d] = NDIMS_W'(d) < ndims;
         ext[d]  = (used[d] && size_ff[d] != '0) ? size_ff[d] : COORD_W'(1);
      end
   end

   // The cell count follows the registers through its own multiplier stages;
   // it has settled before any request reaches the range check.
   logic [2*COORD_W-1:0] p01_ff, p23_ff;
   logic [4*COORD_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      p01_ff   <= (2*COORD_W)'(ext[0]) * (2*COORD_W)'(ext[1]);
      p23_ff   <= (2*COORD_W)'(ext[2]) * (2*COORD_W)'(ext[3]);
      count_ff <= (4*COORD_W)'(p01_ff) * (4*COORD_W)'(p23_ff);
   end

   // ---------------- front end ----------------
   logic      accept;
   logic      v1_ff, v2_ff, v3_ff, v4_ff;
   front_type s1_ff, s2_ff, s3_ff, s4_ff;
   front_type s1_in, s2_in, s3_in, s4_in;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_comb begin
      s1_in       = '0;
      s1_in.act   = req_action;
      s1_in.id    = req_in_cell_id;
      s1_in.coord[0] = used[0] ? req_in_coord0 : '0;
      s1_in.coord[1] = used[1] ? req_in_coord1 : '0;
      s1_in.coord[2] = used[2] ? req_in_coord2 : '0;
      s1_in.coord[3] = used[3] ? req_in_coord3 : '0;
   end

   // Stage 2: subtract the base id, start the offset sum, step the odometer.
   always_comb begin
      logic carry;
      s2_in     = s1_ff;
      s2_in.oor = s1_ff.id < first_cell_ff;
      s2_in.id  = s1_ff.id - first_cell_ff;
      s2_in.acc = OUT_ID_W'(s1_ff.coord[2]) +
                  OUT_ID_W'(ext[2]) * OUT_ID_W'(s1_ff.coord[3]);
      carry = 1'b1;
      for (int d = 0; d < NFIELD; d++) begin
         s2_in.nxt[d] = s1_ff.coord[d];
         if (carry) begin
            if ({1'b0, s1_ff.coord[d]} + (COORD_W+1)'(1) < {1'b0, ext[d]}) begin
               s2_in.nxt[d] = s1_ff.coord[d] + COORD_W'(1);
               carry = 1'b0;
            end else begin
               s2_in.nxt[d] = '0;
            end
         end
      end
      s2_in.wrap = carry;
   end

   // Stage 3: range check against the cell count.
   always_comb begin
      s3_in     = s2_ff;
      s3_in.oor = s2_ff.oor | ({(4*COORD_W-ID_W)'(0), s2_ff.id} >= count_ff);
      s3_in.acc = OUT_ID_W'(s2_ff.coord[1]) + OUT_ID_W'(ext[1]) * s2_ff.acc;
   end

   always_comb begin
      s4_in     = s3_ff;
      s4_in.acc = OUT_ID_W'(s3_ff.coord[0]) + OUT_ID_W'(ext[0]) * s3_ff.acc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
      s4_ff <= s4_in;
   end

   // Stage 5: form the result fields and the dividend.
   logic            v5_ff;
   res_type         r5_ff, r5_in;
   logic [ID_W-1:0] dvd5_ff, dvd5_in;

   always_comb begin
      r5_in     = '0;
      dvd5_in   = '0;
      r5_in.act = s4_ff.act;
      case (s4_ff.act)
         ACT_TO_ID: begin
            r5_in.cell_id = OUT_ID_W'(first_cell_ff) + s4_ff.acc;
         end
         ACT_TO_COORD: begin
            if (s4_ff.oor) begin
               r5_in.status = ST_RANGE;
            end else begin
               dvd5_in = s4_ff.id;
            end
         end
         ACT_NEXT: begin
            r5_in.coord  = s4_ff.nxt;
            r5_in.status = s4_ff.wrap ? ST_WRAP : ST_OK;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      r5_ff   <= r5_in;
      dvd5_ff <= dvd5_in;
   end

   // ---------------- divider chain ----------------
   // Unused dimensions divide by one, which leaves a zero remainder.
   logic            dv_v   [NFIELD+1];
   logic [ID_W-1:0] dv_q   [NFIELD+1];
   res_type         dv_pay [NFIELD+1];

   assign dv_v[0]   = v5_ff;
   assign dv_q[0]   = dvd5_ff;
   assign dv_pay[0] = r5_ff;

   for (genvar d = 0; d < NFIELD; d++) begin : g_dim
      logic               o_v;
      logic [ID_W-1:0]    o_q;
      logic [COORD_W-1:0] o_r;
      logic [PAY_W-1:0]   o_pay;
      res_type            pay_mod;

      gcic_div #(
         .PAY_W(PAY_W)
      ) u_div (
         .clock        (clock),
         .reset        (reset),
         .in_valid     (dv_v[d]),
         .in_dividend  (dv_q[d]),
         .divisor      (ext[d]),
         .in_payload   (PAY_W'(dv_pay[d])),
         .out_valid    (o_v),
         .out_quotient (o_q),
         .out_remainder(o_r),
         .out_payload  (o_pay)
      );

      always_comb begin
         pay_mod = res_type'(o_pay);
         if (pay_mod.act == ACT_TO_COORD) begin
            pay_mod.coord[d] = o_r;
         end
      end

      assign dv_v[d+1]   = o_v;
      assign dv_q[d+1]   = o_q;
      assign dv_pay[d+1] = pay_mod;
   end

   // ---------------- output register ----------------
   logic    rsp_valid_ff;
   res_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_v[NFIELD];
      end
      rsp_ff <= dv_pay[NFIELD];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_cell_id = rsp_ff.cell_id;
   assign rsp_out_coord0  = rsp_ff.coord[0];
   assign rsp_out_coord1  = rsp_ff.coord[1];
   assign rsp_out_coord2  = rsp_ff.coord[2];
   assign rsp_out_coord3  = rsp_ff.coord[3];
   assign rsp_status      = rsp_ff.status;

   // ---------------- assertions ----------------
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result without a matching request");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_RANGE) |->
         (rsp_out_coord0 == '0 && rsp_out_coord1 == '0 &&
          rsp_out_coord2 == '0 && rsp_out_coord3 == '0 && rsp_out_cell_id == '0))
      else $error("out-of-range result carries data");

   a_wrap_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_WRAP) |->
         (rsp_out_coord0 == '0 && rsp_out_coord1 == '0 &&
          rsp_out_coord2 == '0 && rsp_out_coord3 == '0))
      else $error("wrapped result is not all zeros");

endmodule
`default_nettype wire
